// File: rtl/ezr_pkg.sv
// Shared constants, types and arithmetic helpers for the Euler rotation block.
package ezr_pkg;

    localparam int VecWidthDef   = 32;
    localparam int AngleWidthDef = 16;
    localparam int TrigStagesDef = 16;

    localparam int AtanEntries = 24;
    localparam int CW          = 34;   // CORDIC x/y width, Q.30 with headroom
    localparam int AW          = 32;   // CORDIC angle width, Q.28
    localparam int TW          = 33;   // trig value width after sign flip

    localparam logic signed [AW-1:0] AqPi     = 32'sd843314857;
    localparam logic signed [AW-1:0] AqTwoPi  = 32'sd1686629713;
    localparam logic signed [AW-1:0] AqHalfPi = 32'sd421657428;
    localparam logic signed [CW-1:0] CordicGain = 34'sd652032874;

    function automatic logic signed [AW-1:0] atan_q28(input logic [4:0] idx);
        logic signed [AW-1:0] v;
        case (idx)
            5'd0:  v = 32'sd210828714;
            5'd1:  v = 32'sd124459457;
            5'd2:  v = 32'sd65760959;
            5'd3:  v = 32'sd33381290;
            5'd4:  v = 32'sd16755422;
            5'd5:  v = 32'sd8385879;
            5'd6:  v = 32'sd4193963;
            5'd7:  v = 32'sd2097109;
            5'd8:  v = 32'sd1048571;
            5'd9:  v = 32'sd524287;
            5'd10: v = 32'sd262144;
            5'd11: v = 32'sd131072;
            5'd12: v = 32'sd65536;
            5'd13: v = 32'sd32768;
            5'd14: v = 32'sd16384;
            5'd15: v = 32'sd8192;
            5'd16: v = 32'sd4096;
            5'd17: v = 32'sd2048;
            5'd18: v = 32'sd1024;
            5'd19: v = 32'sd512;
            5'd20: v = 32'sd256;
            5'd21: v = 32'sd128;
            5'd22: v = 32'sd64;
            5'd23: v = 32'sd32;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q.30 product rounded back to Q.30.
    function automatic logic signed [TW:0] mul30(input logic signed [TW:0] a,
                                                  input logic signed [TW:0] b);
        logic signed [2*TW+1:0] p;
        p = a * b + (68'sd1 <<< 29);
        return (TW+1)'(p >>> 30);
    endfunction

    // Q.30 to Q.28 with rounding.
    function automatic logic signed [TW:0] to_q28(input logic signed [TW:0] v);
        logic signed [TW:0] t;
        t = v + 34'sd2;
        return t >>> 2;
    endfunction

    typedef struct packed {
        logic signed [TW-1:0] c;
        logic signed [TW-1:0] s;
    } t_trig;

endpackage

// File: rtl/ezr_cordic_cell.sv
// One registered rotation-mode CORDIC step carrying the rest of the item along.
module ezr_cordic_cell #(
    parameter int STAGE = 0,
    parameter int SIDE_W = 8
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [3*ezr_pkg::CW-1:0]    i_x,
    input  logic signed [3*ezr_pkg::CW-1:0]    i_y,
    input  logic signed [3*ezr_pkg::AW-1:0]    i_a,
    input  logic [SIDE_W-1:0]                  i_side,
    output logic signed [3*ezr_pkg::CW-1:0]    o_x,
    output logic signed [3*ezr_pkg::CW-1:0]    o_y,
    output logic signed [3*ezr_pkg::AW-1:0]    o_a,
    output logic [SIDE_W-1:0]                  o_side
);
    localparam int CW = ezr_pkg::CW;
    localparam int AW = ezr_pkg::AW;
    localparam logic signed [AW-1:0] Atan = ezr_pkg::atan_q28(5'(STAGE));

    logic signed [3*CW-1:0] n_x, n_y;
    logic signed [3*AW-1:0] n_a;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [CW-1:0] x, y, xs, ys;
            logic signed [AW-1:0] a;
            x = i_x[k*CW +: CW];
            y = i_y[k*CW +: CW];
            a = i_a[k*AW +: AW];
            xs = x >>> STAGE;
            ys = y >>> STAGE;
            if (!a[AW-1]) begin
                n_x[k*CW +: CW] = x - ys;
                n_y[k*CW +: CW] = y + xs;
                n_a[k*AW +: AW] = a - Atan;
            end else begin
                n_x[k*CW +: CW] = x + ys;
                n_y[k*CW +: CW] = y - xs;
                n_a[k*AW +: AW] = a + Atan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x <= n_x;
            o_y <= n_y;
            o_a <= n_a;
            o_side <= i_side;
        end
    end
endmodule

// File: rtl/euler_zyx_vector_rotation.sv
// Top level: Euler Z-Y-X rotation of a 3-D vector over a CORDIC cell chain.
//
//  channel | dir | fields
//  s_axis  | in  | tdata = vec_x, vec_y, vec_z, roll_rad, pitch_rad, yaw_rad
//  m_axis  | out | tdata = rot_x, rot_y, rot_z
//
// One item enters per clock cycle unless m_axis stalls. Stages: angle fold,
// min(TRIG_STAGES, AtanEntries) CORDIC cells, 7 (matrix products, entries, dot products, rounding).
// The whole pipeline advances together when the output register is empty or
// taken, so a stall at m_axis holds every stage in place.
// Reset (i_rst_n low, synchronous) clears only the stage valid bits.
module euler_zyx_vector_rotation #(
    parameter int VEC_WIDTH   = ezr_pkg::VecWidthDef,
    parameter int ANGLE_WIDTH = ezr_pkg::AngleWidthDef,
    parameter int TRIG_STAGES = ezr_pkg::TrigStagesDef
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // vec_x, vec_y, vec_z, roll_rad, pitch_rad, yaw_rad from bit 0, zero pad
    input  logic [((3*VEC_WIDTH+3*ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // rot_x, rot_y, rot_z from bit 0, zero pad
    output logic [((3*VEC_WIDTH+7)/8)*8-1:0]          m_axis_tdata
);
    localparam int CW  = ezr_pkg::CW;
    localparam int AW  = ezr_pkg::AW;
    localparam int TW  = ezr_pkg::TW;
    localparam int NS  = (TRIG_STAGES < ezr_pkg::AtanEntries) ? TRIG_STAGES
                                                              : ezr_pkg::AtanEntries;
    localparam int VW  = VEC_WIDTH;
    localparam int SIDE_W = 3*VW + 3;   // vector plus three flip flags
    localparam int LAT = 1 + NS + 7;
    localparam int OUT_W = ((3*VW+7)/8)*8;
    localparam int PW  = TW + VW + 2;   // entry times component width
    localparam int SW  = PW + 2;        // sum of three products

    logic adv;
    logic [LAT-1:0] r_vld;

    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // ---- Stage 0: angle scaling and folding into [-pi/2, pi/2].
    logic signed [3*CW-1:0] r_x0, r_y0;
    logic signed [3*AW-1:0] r_a0;
    logic [SIDE_W-1:0]      r_side0;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                logic signed [AW+1:0] a;
                logic flip;
                a = (AW+2)'($signed(s_axis_tdata[3*VW + k*ANGLE_WIDTH +: ANGLE_WIDTH]))
                    <<< (28 - (ANGLE_WIDTH - 4));
                flip = 1'b0;
                if (a > (AW+2)'(ezr_pkg::AqPi))
                    a = a - (AW+2)'(ezr_pkg::AqTwoPi);
                else if (a < -(AW+2)'(ezr_pkg::AqPi))
                    a = a + (AW+2)'(ezr_pkg::AqTwoPi);
                if (a > (AW+2)'(ezr_pkg::AqHalfPi)) begin
                    a = a - (AW+2)'(ezr_pkg::AqPi);
                    flip = 1'b1;
                end else if (a < -(AW+2)'(ezr_pkg::AqHalfPi)) begin
                    a = a + (AW+2)'(ezr_pkg::AqPi);
                    flip = 1'b1;
                end
                r_a0[k*AW +: AW]  <= AW'(a);
                r_x0[k*CW +: CW]  <= ezr_pkg::CordicGain;
                r_y0[k*CW +: CW]  <= '0;
                r_side0[3*VW + k] <= flip;
            end
            r_side0[3*VW-1:0] <= s_axis_tdata[3*VW-1:0];
        end
    end

    // ---- CORDIC cell chain, all three angles side by side.
    logic signed [3*CW-1:0] cx [NS+1];
    logic signed [3*CW-1:0] cy [NS+1];
    logic signed [3*AW-1:0] ca [NS+1];
    logic [SIDE_W-1:0]      cs [NS+1];

    assign cx[0] = r_x0;
    assign cy[0] = r_y0;
    assign ca[0] = r_a0;
    assign cs[0] = r_side0;

    for (genvar g = 0; g < NS; g++) begin : g_cell
        ezr_cordic_cell #(.STAGE(g), .SIDE_W(SIDE_W)) u_cell (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_x   (cx[g]), .i_y (cy[g]), .i_a (ca[g]), .i_side (cs[g]),
            .o_x   (cx[g+1]), .o_y (cy[g+1]), .o_a (ca[g+1]), .o_side (cs[g+1])
        );
    end

    // ---- Sign flip: cosine and sine of roll, pitch, yaw (Q.30).
    ezr_pkg::t_trig tr [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [TW-1:0] xv, yv;
            xv = TW'(cx[NS][k*CW +: CW]);
            yv = TW'(cy[NS][k*CW +: CW]);
            tr[k].c = cs[NS][3*VW + k] ? -xv : xv;
            tr[k].s = cs[NS][3*VW + k] ? -yv : yv;
        end
    end

    // ---- Stage M1: first products.
    logic signed [TW:0] r_cr, r_sr, r_cp, r_sp, r_cysp, r_sysp, r_cycp, r_sycp;
    logic signed [TW:0] r_sy, r_cy;
    logic signed [3*VW-1:0] r_v1;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cr   <= (TW+1)'(tr[0].c);
            r_sr   <= (TW+1)'(tr[0].s);
            r_cp   <= (TW+1)'(tr[1].c);
            r_sp   <= (TW+1)'(tr[1].s);
            r_cy   <= (TW+1)'(tr[2].c);
            r_sy   <= (TW+1)'(tr[2].s);
            r_cysp <= ezr_pkg::mul30((TW+1)'(tr[2].c), (TW+1)'(tr[1].s));
            r_sysp <= ezr_pkg::mul30((TW+1)'(tr[2].s), (TW+1)'(tr[1].s));
            r_cycp <= ezr_pkg::mul30((TW+1)'(tr[2].c), (TW+1)'(tr[1].c));
            r_sycp <= ezr_pkg::mul30((TW+1)'(tr[2].s), (TW+1)'(tr[1].c));
            r_v1   <= cs[NS][3*VW-1:0];
        end
    end

    // ---- Stage M2: second products.
    logic signed [TW:0] r_p [12];
    logic signed [3*VW-1:0] r_v2;
    logic signed [TW:0] r_cpcr_hold;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p[0]  <= r_cycp;
            r_p[1]  <= ezr_pkg::mul30(r_cysp, r_sr);
            r_p[2]  <= ezr_pkg::mul30(r_sy, r_cr);
            r_p[3]  <= ezr_pkg::mul30(r_cysp, r_cr);
            r_p[4]  <= ezr_pkg::mul30(r_sy, r_sr);
            r_p[5]  <= r_sycp;
            r_p[6]  <= ezr_pkg::mul30(r_sysp, r_sr);
            r_p[7]  <= ezr_pkg::mul30(r_cy, r_cr);
            r_p[8]  <= ezr_pkg::mul30(r_sysp, r_cr);
            r_p[9]  <= ezr_pkg::mul30(r_cy, r_sr);
            r_p[10] <= -r_sp;
            r_p[11] <= ezr_pkg::mul30(r_cp, r_sr);
            r_v2    <= r_v1;
            r_cpcr_hold <= ezr_pkg::mul30(r_cp, r_cr);
        end
    end

    // ---- Stage M3: matrix entries in Q.28.
    logic signed [TW:0] r_m [9];
    logic signed [3*VW-1:0] r_v3;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m[0] <= ezr_pkg::to_q28(r_p[0]);
            r_m[1] <= ezr_pkg::to_q28(r_p[1] - r_p[2]);
            r_m[2] <= ezr_pkg::to_q28(r_p[3] + r_p[4]);
            r_m[3] <= ezr_pkg::to_q28(r_p[5]);
            r_m[4] <= ezr_pkg::to_q28(r_p[6] + r_p[7]);
            r_m[5] <= ezr_pkg::to_q28(r_p[8] - r_p[9]);
            r_m[6] <= ezr_pkg::to_q28(r_p[10]);
            r_m[7] <= ezr_pkg::to_q28(r_p[11]);
            r_m[8] <= ezr_pkg::to_q28(r_cpcr_hold);
            r_v3   <= r_v2;
        end
    end

    // ---- Stage M4: entry times component, nine multipliers.
    logic signed [PW-1:0] r_q [9];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 9; j++) begin
                r_q[j] <= PW'(r_m[j] * $signed(r_v3[(j%3)*VW +: VW]));
            end
        end
    end

    // ---- Stage M5: row sums.
    logic signed [SW-1:0] r_sum [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                r_sum[j] <= SW'(r_q[3*j]) + SW'(r_q[3*j+1]) + SW'(r_q[3*j+2]);
            end
        end
    end

    // ---- Stage M6: round from Q.28.
    logic signed [SW-1:0] r_rnd [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                r_rnd[j] <= (r_sum[j] + (SW'(1) <<< 27)) >>> 28;
            end
        end
    end

    // ---- Stage M7: saturate into the output register.
    localparam logic signed [SW-1:0] VMax = SW'((65'sd1 <<< (VW-1)) - 1);
    localparam logic signed [SW-1:0] VMin = -VMax - SW'(1);
    logic [OUT_W-1:0] n_out;
    logic [OUT_W-1:0] r_out;
    always_comb begin
        n_out = '0;
        for (int j = 0; j < 3; j++) begin
            if (r_rnd[j] > VMax)
                n_out[j*VW +: VW] = VW'(VMax);
            else if (r_rnd[j] < VMin)
                n_out[j*VW +: VW] = VW'(VMin);
            else
                n_out[j*VW +: VW] = VW'(r_rnd[j]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end
    assign m_axis_tdata = r_out;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output state");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted item not tracked");
`endif
endmodule
